>>> src/color_format_converter_core_defines.svh
// Assertion macros shared by the color format converter RTL.
// Depends on nothing; files that check their own logic include it by name.
`ifndef COLOR_FORMAT_CONVERTER_CORE_DEFINES_SVH
`define COLOR_FORMAT_CONVERTER_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, reset masks the check
`define CFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfc check failed: same-cycle implication");
// Next-cycle implication, reset masks the check
`define CFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfc check failed: next-cycle implication");
`else
`define CFC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> src/cfc_pkg.sv
// Shared types, codes, palette and helpers of the color format converter.
// Depends on nothing; the interfaces, the divider lane and the top level import it.
package cfc_pkg;

    localparam int CHAN_W      = 8;
    localparam int NUM_W       = 2 * CHAN_W;
    localparam int DIV_STAGES  = CHAN_W;
    localparam int PIPE_STAGES = DIV_STAGES + 2;
    localparam int PAL_SIZE    = 9;

    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

    // Target format codes
    localparam logic [1:0] CMD_RGB  = 2'd0;
    localparam logic [1:0] CMD_RGBA = 2'd1;
    localparam logic [1:0] CMD_CMYK = 2'd2;

    // Source type codes
    localparam logic [2:0] KIND_RGB     = 3'd0;
    localparam logic [2:0] KIND_RGBA    = 3'd1;
    localparam logic [2:0] KIND_CMYK    = 3'd2;
    localparam logic [2:0] KIND_BUILTIN = 3'd3;
    localparam logic [2:0] KIND_SYSTEM  = 3'd4;
    localparam logic [2:0] KIND_STYLE   = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNCONV    = 2'd1;
    localparam logic [1:0] ST_BAD_KIND  = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    // What the back end of the pipe does with an item
    typedef enum logic [1:0] {
        OP_PASS,
        OP_TO_RGB,
        OP_TO_CMYK
    } op_t;

    // Decode stage contents
    typedef struct packed {
        op_t              op;
        logic [1:0]       status;
        logic [CHAN_W-1:0] ch_a;
        logic [CHAN_W-1:0] ch_b;
        logic [CHAN_W-1:0] ch_c;
        logic [CHAN_W-1:0] d;
        logic [CHAN_W-1:0] opnd;
    } s0_t;

    // Numerator stage contents
    typedef struct packed {
        op_t              op;
        logic [1:0]       status;
        logic [CHAN_W-1:0] d;
        logic [NUM_W-1:0]  num_a;
        logic [NUM_W-1:0]  num_b;
        logic [NUM_W-1:0]  num_c;
        logic [CHAN_W-1:0] den;
    } s1_t;

    // Sideband that rides beside the divider lanes
    typedef struct packed {
        op_t              op;
        logic [1:0]       status;
        logic [CHAN_W-1:0] val_a;
        logic [CHAN_W-1:0] val_b;
        logic [CHAN_W-1:0] val_c;
        logic [CHAN_W-1:0] d;
    } side_t;

    // Builtin palette, red in the top byte
    function automatic logic [3*CHAN_W-1:0] palette_rgb(input logic [3:0] idx);
        logic [3*CHAN_W-1:0] rgb;
        case (idx)
            4'd0:    rgb = {8'd255, 8'd255, 8'd255};
            4'd1:    rgb = {8'd255, 8'd0,   8'd0};
            4'd2:    rgb = {8'd255, 8'd165, 8'd0};
            4'd3:    rgb = {8'd255, 8'd255, 8'd0};
            4'd4:    rgb = {8'd0,   8'd128, 8'd0};
            4'd5:    rgb = {8'd0,   8'd255, 8'd255};
            4'd6:    rgb = {8'd0,   8'd0,   8'd255};
            4'd7:    rgb = {8'd128, 8'd0,   8'd128};
            default: rgb = '0;
        endcase
        return rgb;
    endfunction

    // Exact floor(x / 255) for x below 65280
    function automatic logic [CHAN_W-1:0] div255(input logic [NUM_W-1:0] x);
        logic [NUM_W:0] t;
        t = {1'b0, x} + {{(CHAN_W+1){1'b0}}, x[NUM_W-1:CHAN_W]} + {{NUM_W{1'b0}}, 1'b1};
        return t[NUM_W-1:CHAN_W];
    endfunction

endpackage

>>> src/cfc_in_if.sv
// Request channel of the color format converter: valid, ready and one color.
// Depends on cfc_pkg for widths.
interface cfc_in_if import cfc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [2:0]        src_kind;
    logic [CHAN_W-1:0] chan_a;
    logic [CHAN_W-1:0] chan_b;
    logic [CHAN_W-1:0] chan_c;
    logic [CHAN_W-1:0] chan_d;

    modport source (
        output valid, cmd, src_kind, chan_a, chan_b, chan_c, chan_d,
        input  ready
    );
    modport sink (
        input  valid, cmd, src_kind, chan_a, chan_b, chan_c, chan_d,
        output ready
    );
endinterface

>>> src/cfc_out_if.sv
// Result channel of the color format converter: valid, ready and one result.
// Depends on cfc_pkg for widths.
interface cfc_out_if import cfc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_a;
    logic [CHAN_W-1:0] out_b;
    logic [CHAN_W-1:0] out_c;
    logic [CHAN_W-1:0] out_d;
    logic [1:0]        status;

    modport source (
        output valid, out_a, out_b, out_c, out_d, status,
        input  ready
    );
    modport sink (
        input  valid, out_a, out_b, out_c, out_d, status,
        output ready
    );
endinterface

>>> src/cfc_div_lane.sv
// Pipelined restoring divider, one quotient bit per stage, for one ink lane.
// Depends on cfc_pkg; stage enables come from the top level's flow control.
module cfc_div_lane
    import cfc_pkg::*;
(
    input  logic                  clk,
    input  logic [DIV_STAGES-1:0] en,
    input  logic [NUM_W-1:0]      num,
    input  logic [CHAN_W-1:0]     den,
    output logic [CHAN_W-1:0]     quo
);

    logic [NUM_W-1:0]  rem_reg [DIV_STAGES];
    logic [CHAN_W-1:0] den_reg [DIV_STAGES];
    logic [CHAN_W-1:0] quo_reg [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            logic [NUM_W-1:0]  rem_in;
            logic [CHAN_W-1:0] den_in;
            logic [CHAN_W-1:0] quo_in;
            logic [NUM_W-1:0]  sub;
            logic              fit;
            logic [NUM_W-1:0]  rem_next;
            logic [CHAN_W-1:0] quo_next;

            // Take the previous stage, or the lane input at the head
            if (k == 0)
            begin : g_head
                assign rem_in = num;
                assign den_in = den;
                assign quo_in = '0;
            end
            else
            begin : g_body
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign quo_in = quo_reg[k-1];
            end

            // Try to subtract the shifted divisor for this quotient bit
            assign sub = {{CHAN_W{1'b0}}, den_in} << (DIV_STAGES - 1 - k);
            assign fit = rem_in >= sub;

            always_comb
            begin
                rem_next = fit ? (rem_in - sub) : rem_in;
                quo_next = quo_in;
                quo_next[DIV_STAGES-1-k] = fit;
            end

            // Advance when the stage enable allows
            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                    quo_reg[k] <= quo_next;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

>>> src/color_format_converter_core.sv
// Color format converter top level: decode, numerator and divider pipeline.
// Depends on cfc_pkg, cfc_in_if, cfc_out_if, cfc_div_lane and the defines header.
`include "color_format_converter_core_defines.svh"

// Converts one tagged color per request to RGB, RGBA or CMYK. The block takes
// one request every clock cycle when the result channel does not stall and
// returns its result through one decode stage, one numerator stage
// (the 8x8 multipliers for CMYK to RGB) and eight stages of the restoring
// divider that forms the CMYK inks, one quotient bit per stage. Each stage
// holds its item until the next one frees, so empty stages are filled while
// the result side waits and a request is refused only when all ten are full.
// Results leave in request order; the block keeps no state between requests.
module color_format_converter_core
    import cfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cfc_in_if.sink    color,
    cfc_out_if.source result
);

    logic [PIPE_STAGES-1:0] v_reg;
    logic [PIPE_STAGES-1:0] en;

    s0_t   s0_reg, s0_next;
    s1_t   s1_reg, s1_next;
    side_t side_reg [DIV_STAGES];
    side_t side_in;

    logic [3*CHAN_W-1:0] pal;
    logic [1:0]          status;
    logic [2:0]          srck;
    logic [CHAN_W-1:0]   r, g, b, fourth, mx01, mx;
    logic [CHAN_W-1:0]   quo_a, quo_b, quo_c;

    // Flow control: a stage moves when it is empty or its successor moves
    assign en[PIPE_STAGES-1] = !v_reg[PIPE_STAGES-1] || result.ready;
    genvar i;
    generate
        for (i = 0; i < PIPE_STAGES - 1; i++)
        begin : g_en
            assign en[i] = !v_reg[i] || en[i+1];
        end
    endgenerate

    assign color.ready = en[0];

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= color.valid;
            end
            for (int s = 1; s < PIPE_STAGES; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    // Classify the request
    always_comb
    begin
        pal = palette_rgb(color.chan_a[3:0]);
        if (!(color.cmd inside {CMD_RGB, CMD_RGBA, CMD_CMYK}) || color.src_kind > KIND_STYLE)
        begin
            status = ST_BAD_KIND;
        end
        else if (color.src_kind inside {KIND_SYSTEM, KIND_STYLE})
        begin
            status = ST_UNCONV;
        end
        else if (color.src_kind == KIND_BUILTIN &&
                 color.chan_a >= CHAN_W'(PAL_SIZE))
        begin
            status = ST_BAD_INDEX;
        end
        else
        begin
            status = ST_OK;
        end
    end

    // Resolve builtin colors to plain RGB and find the brightest channel
    always_comb
    begin
        if (color.src_kind == KIND_BUILTIN)
        begin
            r      = pal[3*CHAN_W-1:2*CHAN_W];
            g      = pal[2*CHAN_W-1:CHAN_W];
            b      = pal[CHAN_W-1:0];
            fourth = '0;
            srck   = KIND_RGB;
        end
        else
        begin
            r      = color.chan_a;
            g      = color.chan_b;
            b      = color.chan_c;
            fourth = color.chan_d;
            srck   = color.src_kind;
        end
        mx01 = (r > g) ? r : g;
        mx   = (mx01 > b) ? mx01 : b;
    end

    // Pick the operation and its operands
    always_comb
    begin
        s0_next.status = status;
        s0_next.op     = OP_PASS;
        s0_next.ch_a   = r;
        s0_next.ch_b   = g;
        s0_next.ch_c   = b;
        s0_next.d      = fourth;
        s0_next.opnd   = mx;
        if (status != ST_OK)
        begin
            s0_next.ch_a = '0;
            s0_next.ch_b = '0;
            s0_next.ch_c = '0;
            s0_next.d    = '0;
        end
        else if (srck == KIND_CMYK)
        begin
            // CMYK passes through, otherwise scale the inverted inks by 255 - k
            if (color.cmd != CMD_CMYK)
            begin
                s0_next.op   = OP_TO_RGB;
                s0_next.ch_a = ~r;
                s0_next.ch_b = ~g;
                s0_next.ch_c = ~b;
                s0_next.d    = (color.cmd == CMD_RGBA) ? FULL_SCALE : '0;
                s0_next.opnd = ~fourth;
            end
        end
        else if (color.cmd == CMD_CMYK)
        begin
            // Black source gives pure key without a divide
            if (mx == '0)
            begin
                s0_next.ch_a = '0;
                s0_next.ch_b = '0;
                s0_next.ch_c = '0;
                s0_next.d    = FULL_SCALE;
            end
            else
            begin
                s0_next.op   = OP_TO_CMYK;
                s0_next.ch_a = mx - r;
                s0_next.ch_b = mx - g;
                s0_next.ch_c = mx - b;
                s0_next.d    = ~mx;
            end
        end
        else if (color.cmd != {1'b0, srck[1:0]} || srck[2])
        begin
            s0_next.d = (color.cmd == CMD_RGBA) ? FULL_SCALE : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_reg <= s0_next;
        end
    end

    // Form numerators: product for CMYK to RGB, 255 times the gap for inks
    function automatic logic [NUM_W-1:0] numer(input op_t op, input logic [CHAN_W-1:0] ch,
                                              input logic [CHAN_W-1:0] opnd);
        logic [NUM_W-1:0] n;
        case (op)
            OP_TO_RGB:  n = {{CHAN_W{1'b0}}, ch} * {{CHAN_W{1'b0}}, opnd};
            OP_TO_CMYK: n = {ch, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, ch};
            default:    n = {{CHAN_W{1'b0}}, ch};
        endcase
        return n;
    endfunction

    always_comb
    begin
        s1_next.op     = s0_reg.op;
        s1_next.status = s0_reg.status;
        s1_next.d      = s0_reg.d;
        s1_next.num_a  = numer(s0_reg.op, s0_reg.ch_a, s0_reg.opnd);
        s1_next.num_b  = numer(s0_reg.op, s0_reg.ch_b, s0_reg.opnd);
        s1_next.num_c  = numer(s0_reg.op, s0_reg.ch_c, s0_reg.opnd);
        s1_next.den    = s0_reg.opnd;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_reg <= s1_next;
        end
    end

    // Finish the values that need no divider, then carry them alongside
    always_comb
    begin
        side_in.op     = s1_reg.op;
        side_in.status = s1_reg.status;
        side_in.d      = s1_reg.d;
        if (s1_reg.op == OP_TO_RGB)
        begin
            side_in.val_a = div255(s1_reg.num_a);
            side_in.val_b = div255(s1_reg.num_b);
            side_in.val_c = div255(s1_reg.num_c);
        end
        else
        begin
            side_in.val_a = s1_reg.num_a[CHAN_W-1:0];
            side_in.val_b = s1_reg.num_b[CHAN_W-1:0];
            side_in.val_c = s1_reg.num_c[CHAN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            side_reg[0] <= side_in;
        end
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            if (en[s+2])
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // Ink dividers, one lane per channel
    cfc_div_lane u_div_a (
        .clk (clk),
        .en  (en[PIPE_STAGES-1:2]),
        .num (s1_reg.num_a),
        .den (s1_reg.den),
        .quo (quo_a)
    );

    cfc_div_lane u_div_b (
        .clk (clk),
        .en  (en[PIPE_STAGES-1:2]),
        .num (s1_reg.num_b),
        .den (s1_reg.den),
        .quo (quo_b)
    );

    cfc_div_lane u_div_c (
        .clk (clk),
        .en  (en[PIPE_STAGES-1:2]),
        .num (s1_reg.num_c),
        .den (s1_reg.den),
        .quo (quo_c)
    );

    // Drive the result from the last stage
    assign result.valid  = v_reg[PIPE_STAGES-1];
    assign result.out_a  = (side_reg[DIV_STAGES-1].op == OP_TO_CMYK) ? quo_a
                                                                      : side_reg[DIV_STAGES-1].val_a;
    assign result.out_b  = (side_reg[DIV_STAGES-1].op == OP_TO_CMYK) ? quo_b
                                                                      : side_reg[DIV_STAGES-1].val_b;
    assign result.out_c  = (side_reg[DIV_STAGES-1].op == OP_TO_CMYK) ? quo_c
                                                                      : side_reg[DIV_STAGES-1].val_c;
    assign result.out_d  = side_reg[DIV_STAGES-1].d;
    assign result.status = side_reg[DIV_STAGES-1].status;

    // Checks
    `CFC_ASSERT_NEXT(a_accept_loads, clk, rst_n, color.valid && color.ready, v_reg[0])
    `CFC_ASSERT_IMP(a_full_when_refused, clk, rst_n, !color.ready, &v_reg)
    `CFC_ASSERT_IMP(a_ink_divisor_nonzero, clk, rst_n,
                    v_reg[0] && s0_reg.op == OP_TO_CMYK, s0_reg.opnd != '0)
    `CFC_ASSERT_IMP(a_error_zeroes, clk, rst_n,
                    result.valid && result.status != ST_OK,
                    result.out_a == '0 && result.out_b == '0 &&
                    result.out_c == '0 && result.out_d == '0)

endmodule
